@@ hdl/shared_exclusive_lock_table_assert.svh @@
// Assertion macros for the shared/exclusive lock table.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef SHARED_EXCLUSIVE_LOCK_TABLE_ASSERT_SVH
`define SHARED_EXCLUSIVE_LOCK_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SELT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lock table check failed");

`define SELT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lock table check failed");

`else

`define SELT_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define SELT_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/selt_pkg.sv @@
// Package for the shared/exclusive lock table: field widths, command and
// verdict codes, default sizes. Depends on nothing.
`default_nettype none

package selt_pkg;

    localparam int CMD_W     = 2;
    localparam int TXN_W     = 5;
    localparam int ITEM_W    = 8;
    localparam int VERDICT_W = 2;

    localparam int NUM_TXNS_DEF  = 32;
    localparam int NUM_ITEMS_DEF = 256;

    localparam logic [CMD_W-1:0] CMD_SHARED = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXCL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd2;

    localparam logic [VERDICT_W-1:0] V_GRANTED = 2'd0;
    localparam logic [VERDICT_W-1:0] V_DENIED  = 2'd1;
    localparam logic [VERDICT_W-1:0] V_IGNORED = 2'd2;
    localparam logic [VERDICT_W-1:0] V_ENDED   = 2'd3;

endpackage

`default_nettype wire

@@ hdl/selt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module selt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/shared_exclusive_lock_table.sv @@
// Shared/exclusive lock table top level: request register, lock entry RAM,
// decision stage and result register. Depends on selt_pkg, selt_ram and the assert header.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+-----------------------
//  request | req_valid | req_ready | cmd, txn_id, item_id
//  result  | rsp_valid | rsp_ready | verdict
//
// A request reads its item's entry from the RAM at acceptance and is decided
// and written back when the decision stage advances; a new request enters every
// cycle unless a stalled result, a clearing pass or a pending end of session
// holds the input, with the last written entry forwarded to cover the RAM
// read-during-write. After reset and after each end of session a clearing pass
// zeroes all NUM_ITEMS RAM entries; no request is taken meanwhile, nor while an accepted
// end of session waits in the decision stage. A stalled result holds the decision stage.
`default_nettype none
`include "shared_exclusive_lock_table_assert.svh"

module shared_exclusive_lock_table
    import selt_pkg::*;
#(
    parameter int NUM_TXNS  = NUM_TXNS_DEF,
    parameter int NUM_ITEMS = NUM_ITEMS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire logic [CMD_W-1:0]     cmd,
    input  wire logic [TXN_W-1:0]     txn_id,
    input  wire logic [ITEM_W-1:0]    item_id,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output logic [VERDICT_W-1:0]      verdict
);

    localparam int TW = $clog2(NUM_TXNS);
    localparam int IW = $clog2(NUM_ITEMS);
    localparam int EW = 1 + TW + NUM_TXNS;

    logic                 s1_valid_reg;
    logic [CMD_W-1:0]     s1_cmd_reg;
    logic [TW-1:0]        s1_txn_reg;
    logic [IW-1:0]        s1_idx_reg;

    logic                 rsp_valid_reg;
    logic [VERDICT_W-1:0] verdict_reg;

    logic [NUM_TXNS-1:0]  blocked_reg;
    logic [NUM_TXNS-1:0]  blocked_next;

    logic                 fwd_valid_reg;
    logic [IW-1:0]        fwd_idx_reg;
    logic [EW-1:0]        fwd_entry_reg;

    logic                 clr_active_reg;
    logic [IW-1:0]        clr_cnt_reg;

    logic [TW-1:0]        txn_in;
    logic [IW-1:0]        idx_in;
    logic                 accept;
    logic                 s1_adv;
    logic                 s1_end;

    logic [EW-1:0]        rd_entry;
    logic [EW-1:0]        cur_entry;
    logic [EW-1:0]        new_entry;
    logic [VERDICT_W-1:0] verdict_next;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;

    logic                 cur_ov;
    logic [TW-1:0]        cur_ot;
    logic [NUM_TXNS-1:0]  cur_held;
    logic [NUM_TXNS-1:0]  me;

    // fold request fields into table range
    always_comb
    begin
        txn_in = '0;
        for (int i = 0; i < (1 << TXN_W); i++)
        begin
            if (txn_id == TXN_W'(i))
            begin
                txn_in = TW'(i % NUM_TXNS);
            end
        end
    end

    always_comb
    begin
        idx_in = '0;
        for (int i = 0; i < (1 << ITEM_W); i++)
        begin
            if (item_id == ITEM_W'(i))
            begin
                idx_in = IW'(i % NUM_ITEMS);
            end
        end
    end

    assign s1_end    = s1_valid_reg && (s1_cmd_reg == CMD_END);
    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !clr_active_reg && !s1_end && (!s1_valid_reg || s1_adv);
    assign accept    = req_valid && req_ready;

    selt_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_ITEMS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (idx_in),
        .rdata (rd_entry)
    );

    assign cur_entry = (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) ? fwd_entry_reg
                                                                      : rd_entry;
    assign cur_ov    = cur_entry[EW-1];
    assign cur_ot    = cur_entry[EW-2 -: TW];
    assign cur_held  = cur_entry[NUM_TXNS-1:0];
    assign me        = {{(NUM_TXNS-1){1'b0}}, 1'b1} << s1_txn_reg;

    // decide
    always_comb
    begin
        new_entry    = cur_entry;
        verdict_next = V_GRANTED;
        blocked_next = blocked_reg;
        if (s1_cmd_reg == CMD_END)
        begin
            verdict_next = V_ENDED;
            blocked_next = '0;
        end
        else if (blocked_reg[s1_txn_reg])
        begin
            verdict_next = V_IGNORED;
        end
        else if (cur_ov && (cur_ot != s1_txn_reg))
        begin
            verdict_next              = V_DENIED;
            blocked_next[s1_txn_reg]  = 1'b1;
        end
        else if (s1_cmd_reg == CMD_SHARED)
        begin
            new_entry[NUM_TXNS-1:0] = cur_held | me;
        end
        else if (cur_ov)
        begin
            verdict_next = V_GRANTED;
        end
        else if ((cur_held != '0) && (cur_held != me))
        begin
            verdict_next              = V_DENIED;
            blocked_next[s1_txn_reg]  = 1'b1;
        end
        else
        begin
            new_entry = {1'b1, s1_txn_reg, cur_held | me};
        end
    end

    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = s1_adv && !s1_end;
            ram_waddr = s1_idx_reg;
            ram_wdata = new_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            blocked_reg    <= '0;
            fwd_valid_reg  <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                blocked_reg <= blocked_next;
                if (s1_end)
                begin
                    fwd_valid_reg  <= 1'b0;
                    clr_active_reg <= 1'b1;
                    clr_cnt_reg    <= '0;
                end
                else
                begin
                    fwd_valid_reg <= 1'b1;
                end
            end
            else if (clr_active_reg)
            begin
                if (clr_cnt_reg == IW'(NUM_ITEMS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= cmd;
            s1_txn_reg <= txn_in;
            s1_idx_reg <= idx_in;
        end
        if (s1_adv)
        begin
            verdict_reg   <= verdict_next;
            fwd_idx_reg   <= s1_idx_reg;
            fwd_entry_reg <= new_entry;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign verdict   = verdict_reg;

    `SELT_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, clr_active_reg, !req_ready)
    `SELT_ASSERT_IMP(a_end_holds_input, clk, rst_n, s1_end, !req_ready)
    `SELT_ASSERT_NXT(a_end_starts_clear, clk, rst_n, s1_adv && s1_end,
        clr_active_reg && (clr_cnt_reg == '0) && (blocked_reg == '0) && !fwd_valid_reg)
    `SELT_ASSERT_NXT(a_fwd_tracks_write, clk, rst_n, s1_adv && !s1_end,
        fwd_valid_reg && (fwd_idx_reg == $past(s1_idx_reg)))

endmodule

`default_nettype wire

@@ sim/lock_verdict_checker.sv @@
// Checker for the shared/exclusive lock table: watches both channels, keeps its own lock
// table, predicts each verdict and compares it with the block's. Depends on selt_pkg.
`timescale 1ns / 100ps

module lock_verdict_checker
    import selt_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic                 req_ready,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [TXN_W-1:0]     txn_id,
    input  logic [ITEM_W-1:0]    item_id,
    input  logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  logic [VERDICT_W-1:0] verdict,
    output int unsigned          mismatches,
    output int unsigned          outstanding
);

    localparam int TXNS  = NUM_TXNS_DEF;
    localparam int ITEMS = NUM_ITEMS_DEF;

    logic                 txn_blocked [TXNS];
    logic                 item_owned  [ITEMS];
    logic [TXN_W-1:0]     item_owner  [ITEMS];
    logic [TXNS-1:0]      item_holders[ITEMS];
    logic [VERDICT_W-1:0] expected_verdicts[$];

    function automatic void clear_lock_table();
        for (int i = 0; i < TXNS; i++)
            txn_blocked[i] = 1'b0;
        for (int i = 0; i < ITEMS; i++)
        begin
            item_owned[i]   = 1'b0;
            item_owner[i]   = '0;
            item_holders[i] = '0;
        end
    endfunction

    function automatic logic [VERDICT_W-1:0] predict_verdict(
        input logic [CMD_W-1:0]  c,
        input logic [TXN_W-1:0]  t_raw,
        input logic [ITEM_W-1:0] it_raw
    );
        int              t;
        int              it;
        logic [TXNS-1:0] me;
        logic [TXNS-1:0] held;
        t  = int'(t_raw) % TXNS;
        it = int'(it_raw) % ITEMS;
        me = '0;
        me[t] = 1'b1;
        held = item_holders[it];
        if (c == CMD_END)
        begin
            clear_lock_table();
            return V_ENDED;
        end
        if (txn_blocked[t])
            return V_IGNORED;
        if (item_owned[it] && int'(item_owner[it]) != t)
        begin
            txn_blocked[t] = 1'b1;
            return V_DENIED;
        end
        if (c == CMD_SHARED)
        begin
            item_holders[it] = held | me;
            return V_GRANTED;
        end
        // exclusive, including the unused command code
        if (item_owned[it])
            return V_GRANTED;
        if (held != '0 && held != me)
        begin
            txn_blocked[t] = 1'b1;
            return V_DENIED;
        end
        item_owned[it]   = 1'b1;
        item_owner[it]   = TXN_W'(t);
        item_holders[it] = held | me;
        return V_GRANTED;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [VERDICT_W-1:0] want;
        int unsigned          fails;
        if (!rst_n)
        begin
            clear_lock_table();
            expected_verdicts.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            fails = mismatches;
            if (rsp_valid && rsp_ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    if (fails < 10)
                        $display("%0t: unexpected result, verdict %0d", $realtime, verdict);
                    fails++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (verdict !== want)
                    begin
                        if (fails < 10)
                            $display("%0t: verdict mismatch, expected %0d, got %0d",
                                     $realtime, want, verdict);
                        fails++;
                    end
                end
            end
            if (req_valid && req_ready)
                expected_verdicts.push_back(predict_verdict(cmd, txn_id, item_id));
            mismatches  <= fails;
            outstanding <= expected_verdicts.size();
        end
    end

endmodule

@@ sim/shared_exclusive_lock_table_test.sv @@
// Testbench top for the shared/exclusive lock table: clock, reset, directed and random requests
// under several idling patterns, verdict. Depends on selt_pkg, the DUT and lock_verdict_checker.
`timescale 1ns / 100ps

module shared_exclusive_lock_table_test;

    import selt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED     = 2'd3;
    localparam int unsigned      RANDOM_REQUESTS = 1260;
    localparam int unsigned      CYCLE_LIMIT     = 400000;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_ready;
    logic [CMD_W-1:0]     cmd;
    logic [TXN_W-1:0]     txn_id;
    logic [ITEM_W-1:0]    item_id;
    logic                 rsp_valid;
    logic                 rsp_ready;
    logic [VERDICT_W-1:0] verdict;
    int unsigned          mismatches;
    int unsigned          outstanding;
    int unsigned          cycle_count = 0;
    int unsigned          idle_pct;
    int unsigned          stall_pct;

    shared_exclusive_lock_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .txn_id    (txn_id),
        .item_id   (item_id),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .verdict   (verdict)
    );

    lock_verdict_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .cmd         (cmd),
        .txn_id      (txn_id),
        .item_id     (item_id),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .verdict     (verdict),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("shared_exclusive_lock_table verification failed");
            $finish;
        end
    end

    always @(posedge clk)
        rsp_ready <= ($urandom_range(99) >= stall_pct);

    task automatic issue_request(
        input logic [CMD_W-1:0]  c,
        input logic [TXN_W-1:0]  t,
        input logic [ITEM_W-1:0] it
    );
        while ($urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        cmd       <= c;
        txn_id    <= t;
        item_id   <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned          sent;
        int unsigned          session;
        int unsigned          length;
        int unsigned          pick;
        logic [TXN_W-1:0]     txn_base;
        int unsigned          txn_span;
        logic [ITEM_W-1:0]    item_base;
        int unsigned          item_span;
        logic [CMD_W-1:0]     c;
        logic [TXN_W-1:0]     t;
        logic [ITEM_W-1:0]    it;

        idle_pct    = 0;
        stall_pct   = 0;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        cmd         = CMD_SHARED;
        txn_id      = '0;
        item_id     = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_request(CMD_SHARED, 5'd0,  8'd0);
        issue_request(CMD_SHARED, 5'd31, 8'd0);
        issue_request(CMD_EXCL,   5'd0,  8'd0);    // two holders: deny, block
        issue_request(CMD_SHARED, 5'd0,  8'd5);    // blocked: ignore
        issue_request(CMD_END,    5'd0,  8'd0);    // blocked txn may still end
        issue_request(CMD_EXCL,   5'd0,  8'd255);  // txn zero as owner
        issue_request(CMD_EXCL,   5'd0,  8'd255);  // already owner
        issue_request(CMD_SHARED, 5'd0,  8'd255);
        issue_request(CMD_SHARED, 5'd1,  8'd255);  // other owner: deny
        issue_request(CMD_EXCL,   5'd1,  8'd7);
        issue_request(CMD_UNUSED, 5'd2,  8'd128);  // unused code as exclusive
        issue_request(CMD_EXCL,   5'd3,  8'd128);
        issue_request(CMD_SHARED, 5'd4,  8'd9);
        issue_request(CMD_EXCL,   5'd4,  8'd9);    // sole holder upgrades
        issue_request(CMD_SHARED, 5'd5,  8'd10);
        issue_request(CMD_EXCL,   5'd6,  8'd10);   // one other holder: deny
        issue_request(CMD_EXCL,   5'd31, 8'd255);
        issue_request(CMD_SHARED, 5'd30, 8'd254);
        issue_request(CMD_UNUSED, 5'd31, 8'd254);
        issue_request(CMD_END,    5'd31, 8'd255);

        sent    = 0;
        session = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            case (session % 5)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 54; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 54; end
                3: begin idle_pct = 37; stall_pct = 37; end
                default: begin idle_pct = $urandom_range(60); stall_pct = $urandom_range(60); end
            endcase
            length    = $urandom_range(60, 8);
            txn_base  = TXN_W'($urandom_range(31));
            txn_span  = $urandom_range(7, 1);
            item_base = ITEM_W'($urandom_range(255));
            item_span = $urandom_range(15);
            for (int k = 0; k < length; k++)
            begin
                pick = $urandom_range(99);
                if (pick < 2)
                    c = CMD_END;
                else if (pick < 7)
                    c = CMD_UNUSED;
                else if (pick < 52)
                    c = CMD_SHARED;
                else
                    c = CMD_EXCL;
                if ($urandom_range(9) == 0)
                    t = TXN_W'($urandom_range(31));
                else
                    t = txn_base + TXN_W'($urandom_range(txn_span));
                if ($urandom_range(9) == 0)
                    it = ITEM_W'($urandom_range(255));
                else
                    it = item_base + ITEM_W'($urandom_range(item_span));
                issue_request(c, t, it);
                sent++;
            end
            issue_request(CMD_END, TXN_W'($urandom_range(31)), ITEM_W'($urandom_range(255)));
            sent++;
            session++;
        end
        req_valid <= 1'b0;
        @(posedge clk);

        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("shared_exclusive_lock_table verification clean");
        else
            $display("shared_exclusive_lock_table verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/selt_pkg.sv
hdl/selt_ram.sv
hdl/shared_exclusive_lock_table.sv
sim/lock_verdict_checker.sv
sim/shared_exclusive_lock_table_test.sv
